// ===== rtl/gwa_pkg.sv =====
// Shared constants and helpers for the weighted Gram accumulator.
// Holds field widths, register indexes and the triangle addressing function.
// No dependencies.
package gwa_pkg;

    localparam int MAX_COLS  = 8;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CNT_W     = $clog2(MAX_COLS + 1);
    localparam int TRI_SIZE  = (MAX_COLS * (MAX_COLS + 1)) / 2;
    localparam int ADDR_W    = $clog2(TRI_SIZE);

    localparam int ENTRY_W   = 16;
    localparam int WEIGHT_W  = 16;
    localparam int ACC_W     = 40;
    localparam int P1_W      = 2 * ENTRY_W;
    localparam int P2_W      = P1_W + WEIGHT_W;
    localparam int RND_SHIFT = 15;
    localparam int TERM_W    = P2_W - RND_SHIFT;

    // Weight of exactly 1.0 in Q1.15.
    localparam logic [WEIGHT_W:0] WEIGHT_ONE = (WEIGHT_W + 1)'(1 << RND_SHIFT);
    localparam logic signed [P2_W-1:0] RND_HALF = P2_W'(1 << (RND_SHIFT - 1));

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTING_ON = CFG_IDX_W'(1);

    // Address of upper-triangle entry (a, b), a <= b. Rows of the triangle are
    // stacked, row r holding MAX_COLS - r entries.
    function automatic logic [ADDR_W-1:0] tri_slot(input logic [COL_W-1:0] a,
                                                  input logic [COL_W-1:0] b);
        logic [ADDR_W-1:0] base;
        base = '0;
        for (int r = 0; r < MAX_COLS; r++)
        begin
            if (r < int'(a))
            begin
                base = base + ADDR_W'(MAX_COLS - r);
            end
        end
        return base + ADDR_W'(b - a);
    endfunction

endpackage

// ===== rtl/weighted_gram_accumulator.sv =====
// Weighted Gram accumulator top level: builds A^T diag(w) A row by row.
// Keeps the upper triangle in a single-port-read synchronous memory.
// Depends on gwa_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | sink      | in_valid / in_ready  | entry_0..entry_7, row_weight, last_row
//  out     | source    | out_valid / out_ready| result_row, value_0..value_7, final_row
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item issues the entries of its triangle one per cycle into a four-stage
// read, multiply, round, add-and-write pipeline, which drains before the next
// item is taken. A last item then builds the result rows one at a time, one
// read per column, each row waiting until the one before it has been taken.
// The store is cleared at reset and after every last item by a per-entry
// valid vector, so no clearing sweep is needed. Configuration is always ready.
module weighted_gram_accumulator
    import gwa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [ENTRY_W-1:0]   entry_0,
    input  logic signed [ENTRY_W-1:0]   entry_1,
    input  logic signed [ENTRY_W-1:0]   entry_2,
    input  logic signed [ENTRY_W-1:0]   entry_3,
    input  logic signed [ENTRY_W-1:0]   entry_4,
    input  logic signed [ENTRY_W-1:0]   entry_5,
    input  logic signed [ENTRY_W-1:0]   entry_6,
    input  logic signed [ENTRY_W-1:0]   entry_7,
    input  logic [WEIGHT_W-1:0]         row_weight,
    input  logic                        last_row,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COL_W-1:0]            result_row,
    output logic signed [ACC_W-1:0]     value_0,
    output logic signed [ACC_W-1:0]     value_1,
    output logic signed [ACC_W-1:0]     value_2,
    output logic signed [ACC_W-1:0]     value_3,
    output logic signed [ACC_W-1:0]     value_4,
    output logic signed [ACC_W-1:0]     value_5,
    output logic signed [ACC_W-1:0]     value_6,
    output logic signed [ACC_W-1:0]     value_7,
    output logic                        final_row
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ACC      = 3'd1;
    localparam logic [2:0] ST_DRAIN    = 3'd2;
    localparam logic [2:0] ST_OUT_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT_RD   = 3'd4;
    localparam logic [2:0] ST_OUT_FIN  = 3'd5;

    // Configuration registers.
    logic [CNT_W-1:0]               cols_reg;
    logic                           wt_on_reg;

    // Control.
    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [COL_W-1:0]               last_col_reg;   // effective column count minus one
    logic                           last_item_reg;
    logic [COL_W-1:0]               ai_reg;
    logic [COL_W-1:0]               aj_reg;
    logic [ADDR_W-1:0]              slot_reg;
    logic [COL_W-1:0]               k_reg;          // product row being emitted
    logic [COL_W-1:0]               oc_reg;         // column being read for it

    // Captured item.
    logic signed [ENTRY_W-1:0]      ent_reg [MAX_COLS];
    logic [WEIGHT_W:0]              w_reg;

    // Accumulation pipeline.
    logic                           s1_vld_reg;
    logic                           s2_vld_reg;
    logic                           s3_vld_reg;
    logic [ADDR_W-1:0]              s1_addr_reg;
    logic [ADDR_W-1:0]              s2_addr_reg;
    logic [ADDR_W-1:0]              s3_addr_reg;
    logic signed [P1_W-1:0]         prod1_reg;
    logic signed [P2_W-1:0]         prod2_reg;
    logic signed [TERM_W-1:0]       term_reg;
    logic signed [ACC_W-1:0]        acc2_reg;
    logic signed [ACC_W-1:0]        acc3_reg;

    // Memory and its per-entry valid bits.
    logic signed [ACC_W-1:0]        gram_mem [TRI_SIZE];
    logic [TRI_SIZE-1:0]            valid_reg;
    logic signed [ACC_W-1:0]        rd_data_reg;
    logic                           rd_hit_reg;
    logic [ADDR_W-1:0]              rd_addr;
    logic [ADDR_W-1:0]              out_slot;
    logic                           wr_en;
    logic signed [ACC_W-1:0]        wr_data;

    // Result gathering.
    logic                           g_vld_reg;
    logic [COL_W-1:0]               g_col_reg;
    logic signed [ACC_W-1:0]        val_reg [MAX_COLS];
    logic                           out_valid_reg;
    logic [COL_W-1:0]               out_row_reg;
    logic                           out_final_reg;

    logic                           in_accept;
    logic                           issue;
    logic                           item_done;
    logic                           pipe_busy;
    logic [COL_W-1:0]               lo_col;
    logic [COL_W-1:0]               hi_col;
    logic [COL_W-1:0]               eff_last;
    logic signed [ENTRY_W-1:0]      op_a;
    logic signed [ENTRY_W-1:0]      op_b;
    logic signed [P2_W-1:0]         rnd_sum;
    logic signed [ACC_W:0]          acc_sum;
    logic                           last_out_row;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign issue       = (state_reg == ST_ACC);
    assign pipe_busy   = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign item_done   = (ai_reg == last_col_reg) && (aj_reg == last_col_reg);
    assign last_out_row = (k_reg == last_col_reg);

    // A column count of zero acts as one, and counts past the maximum clamp.
    always_comb
    begin
        if (cols_reg == '0)
        begin
            eff_last = '0;
        end
        else if (cols_reg > CNT_W'(MAX_COLS))
        begin
            eff_last = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            eff_last = COL_W'(cols_reg - CNT_W'(1));
        end
    end

    // The product matrix is symmetric: read (min, max) from the triangle.
    assign lo_col   = (k_reg < oc_reg) ? k_reg : oc_reg;
    assign hi_col   = (k_reg < oc_reg) ? oc_reg : k_reg;
    assign out_slot = tri_slot(lo_col, hi_col);
    assign rd_addr  = (state_reg == ST_OUT_RD) ? out_slot : slot_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (item_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = last_item_reg ? ST_OUT_WAIT : ST_IDLE;
                end
            end
            ST_OUT_WAIT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:
            begin
                if (oc_reg == last_col_reg)
                begin
                    state_next = ST_OUT_FIN;
                end
            end
            ST_OUT_FIN:
            begin
                state_next = last_out_row ? ST_IDLE : ST_OUT_WAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= CNT_W'(MAX_COLS);
            wt_on_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_COLS_IN_USE)
            begin
                cols_reg <= CNT_W'(cfg_data);
            end
            else if (cfg_index == REG_WEIGHTING_ON)
            begin
                wt_on_reg <= cfg_data[0];
            end
        end
    end

    // Sequencer and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_col_reg  <= '0;
            last_item_reg <= 1'b0;
            ai_reg        <= '0;
            aj_reg        <= '0;
            slot_reg      <= '0;
            k_reg         <= '0;
            oc_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                last_col_reg  <= eff_last;
                last_item_reg <= last_row;
                ai_reg        <= '0;
                aj_reg        <= '0;
                slot_reg      <= '0;
                k_reg         <= '0;
            end
            else if (issue && !item_done)
            begin
                // Walk the triangle row by row, one entry per cycle.
                if (aj_reg == last_col_reg)
                begin
                    ai_reg   <= ai_reg + COL_W'(1);
                    aj_reg   <= ai_reg + COL_W'(1);
                    slot_reg <= tri_slot(ai_reg + COL_W'(1), ai_reg + COL_W'(1));
                end
                else
                begin
                    aj_reg   <= aj_reg + COL_W'(1);
                    slot_reg <= slot_reg + ADDR_W'(1);
                end
            end
            if (state_reg == ST_OUT_WAIT)
            begin
                oc_reg <= '0;
            end
            else if (state_reg == ST_OUT_RD && oc_reg != last_col_reg)
            begin
                oc_reg <= oc_reg + COL_W'(1);
            end
            if (state_reg == ST_OUT_FIN && !last_out_row)
            begin
                k_reg <= k_reg + COL_W'(1);
            end
        end
    end

    // Item capture. A weight of 1.0 stands in when weighting is off.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ent_reg[0] <= entry_0;
            ent_reg[1] <= entry_1;
            ent_reg[2] <= entry_2;
            ent_reg[3] <= entry_3;
            ent_reg[4] <= entry_4;
            ent_reg[5] <= entry_5;
            ent_reg[6] <= entry_6;
            ent_reg[7] <= entry_7;
            w_reg      <= wt_on_reg ? {1'b0, row_weight} : WEIGHT_ONE;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            g_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            g_vld_reg  <= (state_reg == ST_OUT_RD);
            if (state_reg == ST_OUT_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign op_a    = ent_reg[ai_reg];
    assign op_b    = ent_reg[aj_reg];
    // Drop the 15 fraction bits of the Q1.15 weight, rounding half up.
    assign rnd_sum = prod2_reg + RND_HALF;
    assign acc_sum = {acc3_reg[ACC_W-1], acc3_reg}
                   + {{(ACC_W + 1 - TERM_W){term_reg[TERM_W-1]}}, term_reg};

    // Saturate to the 40-bit accumulator range.
    always_comb
    begin
        priority if (!acc_sum[ACC_W] && acc_sum[ACC_W-1])
        begin
            wr_data = ACC_MAX;
        end
        else if (acc_sum[ACC_W] && !acc_sum[ACC_W-1])
        begin
            wr_data = ACC_MIN;
        end
        else
        begin
            wr_data = acc_sum[ACC_W-1:0];
        end
    end

    assign wr_en = s3_vld_reg;

    // Pipeline payload: multiply the two entries, then by the weight, then
    // round, then add into the value read from the store.
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= slot_reg;
        prod1_reg   <= P1_W'(op_a) * P1_W'(op_b);
        s2_addr_reg <= s1_addr_reg;
        prod2_reg   <= P2_W'(prod1_reg) * P2_W'($signed(w_reg));
        acc2_reg    <= rd_hit_reg ? rd_data_reg : '0;
        s3_addr_reg <= s2_addr_reg;
        term_reg    <= TERM_W'(rnd_sum >>> RND_SHIFT);
        acc3_reg    <= acc2_reg;
    end

    // Triangle store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gram_mem[s3_addr_reg] <= wr_data;
        end
        rd_data_reg <= gram_mem[rd_addr];
        rd_hit_reg  <= valid_reg[rd_addr];
    end

    // An entry never written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (state_reg == ST_OUT_FIN && last_out_row)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[s3_addr_reg] <= 1'b1;
        end
    end

    // Result row assembly; columns past the count stay zero.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT_WAIT && !out_valid_reg)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                val_reg[c] <= '0;
            end
        end
        else if (g_vld_reg)
        begin
            val_reg[g_col_reg] <= rd_hit_reg ? rd_data_reg : '0;
        end
        g_col_reg <= oc_reg;
        if (state_reg == ST_OUT_FIN)
        begin
            out_row_reg   <= k_reg;
            out_final_reg <= last_out_row;
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_row = out_row_reg;
    assign final_row  = out_final_reg;
    assign value_0    = val_reg[0];
    assign value_1    = val_reg[1];
    assign value_2    = val_reg[2];
    assign value_3    = val_reg[3];
    assign value_4    = val_reg[4];
    assign value_5    = val_reg[5];
    assign value_6    = val_reg[6];
    assign value_7    = val_reg[7];

    // A new item is only taken once the previous one has been written back.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pipe_busy)
        else $error("item accepted with accumulation still in flight");

    // Within one item every slot is touched once, so a write-back never
    // targets the entry being read in the same cycle.
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_vld_reg && issue) |-> (s3_addr_reg != slot_reg))
        else $error("read-modify-write overlap on one triangle entry");

    // Result gathering reads only a settled store.
    a_gather_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        g_vld_reg |-> !wr_en)
        else $error("store written while a result row is read");

    // Every write-back lands inside the triangle.
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s3_addr_reg < ADDR_W'(TRI_SIZE)))
        else $error("write-back address outside the triangle");

    // The store is cleared only after the final result row has been built.
    a_clear_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT_FIN && last_out_row) |=> (out_valid_reg && out_final_reg))
        else $error("store cleared without a final result row");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for weighted_gram_accumulator: random and directed rows of A
// are fed through valid/ready channels and every product row is checked on arrival.
// Depends on gwa_pkg and the weighted_gram_accumulator RTL.
module testbench;
    import gwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    // The idle drain at the end of settle() covers any row that is still in
    // flight inside the block when the last result has left.
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 400_000;

    // Index 2 maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);

    localparam logic [ENTRY_W-1:0] ENTRY_MIN = 16'h8000;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = 16'h7FFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'hFFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_UNIT = 16'h8000;

    // One row of A as it crosses the input channel.
    typedef struct packed {
        logic [MAX_COLS-1:0][ENTRY_W-1:0] entry;
        logic [WEIGHT_W-1:0]              weight;
        logic                             is_last;
    } gram_row_t;

    // One row of the product matrix as it leaves the block.
    typedef struct packed {
        logic [COL_W-1:0]               row;
        logic [MAX_COLS-1:0][ACC_W-1:0] value;
        logic                           is_last;
    } product_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [ENTRY_W-1:0]  entry_0 = '0;
    logic [ENTRY_W-1:0]  entry_1 = '0;
    logic [ENTRY_W-1:0]  entry_2 = '0;
    logic [ENTRY_W-1:0]  entry_3 = '0;
    logic [ENTRY_W-1:0]  entry_4 = '0;
    logic [ENTRY_W-1:0]  entry_5 = '0;
    logic [ENTRY_W-1:0]  entry_6 = '0;
    logic [ENTRY_W-1:0]  entry_7 = '0;
    logic [WEIGHT_W-1:0] row_weight = '0;
    logic                last_row = 1'b0;

    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [COL_W-1:0] result_row;
    logic [ACC_W-1:0] value_0;
    logic [ACC_W-1:0] value_1;
    logic [ACC_W-1:0] value_2;
    logic [ACC_W-1:0] value_3;
    logic [ACC_W-1:0] value_4;
    logic [ACC_W-1:0] value_5;
    logic [ACC_W-1:0] value_6;
    logic [ACC_W-1:0] value_7;
    logic             final_row;

    weighted_gram_accumulator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .entry_0    (entry_0),
        .entry_1    (entry_1),
        .entry_2    (entry_2),
        .entry_3    (entry_3),
        .entry_4    (entry_4),
        .entry_5    (entry_5),
        .entry_6    (entry_6),
        .entry_7    (entry_7),
        .row_weight (row_weight),
        .last_row   (last_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_row (result_row),
        .value_0    (value_0),
        .value_1    (value_1),
        .value_2    (value_2),
        .value_3    (value_3),
        .value_4    (value_4),
        .value_5    (value_5),
        .value_6    (value_6),
        .value_7    (value_7),
        .final_row  (final_row)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shared bench state.
    // ------------------------------------------------------------------
    gram_row_t    pending_rows[$];       // rows waiting for the driver
    product_row_t expected_products[$];  // predicted product rows, oldest first
    int           rows_pushed = 0;
    int           rows_accepted = 0;
    int           mismatches = 0;
    int           send_idle_pct = 0;     // chance that the driver leaves a cycle empty
    int           stall_pct = 0;         // chance that the receiver drops out_ready
    int           hold_requests = 0;     // bumped by the stimulus to ask for a long hold
    int           hold_served = 0;
    int           hold_left = 0;
    int           cycle_count = 0;
    gram_row_t    drive_row;

    // The bench's own picture of the block: the upper triangle of G, kept in
    // 64-bit integers that are clamped to the 40-bit range on every add, plus
    // the two configuration registers with their reset values.
    longint         gram_tri[TRI_SIZE];
    logic [3:0]     model_cols = 4'd8;
    logic           model_weighting = 1'b1;

    initial
    begin
        for (int s = 0; s < TRI_SIZE; s++)
        begin
            gram_tri[s] = 0;
        end
    end

    // Position of triangle entry (a, b), a <= b, with row r of the triangle
    // holding MAX_COLS - r entries stacked one after another.
    function automatic int tri_pos(input int a, input int b);
        return a * MAX_COLS - (a * (a - 1)) / 2 + (b - a);
    endfunction

    // Folds one accepted row into the triangle. A row flagged last then yields
    // one mirrored product row per column in use, and the whole store is wiped.
    function automatic void accumulate_gram_row(input gram_row_t r);
        int           n;
        longint       e[MAX_COLS];
        longint       w;
        longint       term;
        longint       acc;
        product_row_t p;

        // A column count of zero behaves as one, anything past eight as eight.
        n = (model_cols == 0) ? 1 : ((model_cols > MAX_COLS) ? MAX_COLS : int'(model_cols));
        for (int c = 0; c < MAX_COLS; c++)
        begin
            e[c] = longint'($signed(r.entry[c]));
        end
        // With weighting off every row counts as weight 1.0, which is exact in Q1.15.
        w = model_weighting ? longint'(r.weight) : longint'(WEIGHT_UNIT);

        for (int i = 0; i < n; i++)
        begin
            for (int j = i; j < n; j++)
            begin
                // The triple product has 15 fraction bits from the weight; rounding adds half
                // an LSB and floors, so ties go toward plus infinity.
                term = (e[i] * e[j] * w + 64'sd16384) >>> 15;
                acc = gram_tri[tri_pos(i, j)] + term;
                if (acc > longint'(ACC_MAX))
                begin
                    acc = longint'(ACC_MAX);
                end
                else if (acc < longint'(ACC_MIN))
                begin
                    acc = longint'(ACC_MIN);
                end
                gram_tri[tri_pos(i, j)] = acc;
            end
        end

        if (r.is_last)
        begin
            for (int k = 0; k < n; k++)
            begin
                p.row = COL_W'(k);
                for (int j = 0; j < MAX_COLS; j++)
                begin
                    // Columns outside the count read zero, even where a larger
                    // count earlier in the set left something in the store.
                    if (j < n)
                    begin
                        p.value[j] = gram_tri[(k < j) ? tri_pos(k, j) : tri_pos(j, k)][ACC_W-1:0];
                    end
                    else
                    begin
                        p.value[j] = '0;
                    end
                end
                p.is_last = (k == n - 1);
                expected_products.push_back(p);
            end
            for (int s = 0; s < TRI_SIZE; s++)
            begin
                gram_tri[s] = 0;
            end
        end
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Input driver: takes the next row from the queue whenever the channel is
    // free, except in cycles that the current idle rate leaves empty. A row
    // once offered stays on the port untouched until it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_row = pending_rows.pop_front();
                entry_0    <= drive_row.entry[0];
                entry_1    <= drive_row.entry[1];
                entry_2    <= drive_row.entry[2];
                entry_3    <= drive_row.entry[3];
                entry_4    <= drive_row.entry[4];
                entry_5    <= drive_row.entry[5];
                entry_6    <= drive_row.entry[6];
                entry_7    <= drive_row.entry[7];
                row_weight <= drive_row.weight;
                last_row   <= drive_row.is_last;
                in_valid   <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long hold on the output side, counted here on its own. The stimulus asks
    // for it by bumping hold_requests; until it runs out the receiver refuses
    // every product row, so the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
    end

    // Receiver: stalls at random at the current rate, and fully during a hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the bench's
    // own nonblocking updates land, so it sees exactly what each handshake moved.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        gram_row_t    seen_row;
        product_row_t got;
        product_row_t want;

        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_COLS_IN_USE)
                begin
                    model_cols = cfg_data;
                end
                else if (cfg_index == REG_WEIGHTING_ON)
                begin
                    model_weighting = cfg_data[0];
                end
            end

            if (in_valid && in_ready)
            begin
                seen_row.entry = {entry_7, entry_6, entry_5, entry_4,
                                  entry_3, entry_2, entry_1, entry_0};
                seen_row.weight = row_weight;
                seen_row.is_last = last_row;
                rows_accepted++;
                accumulate_gram_row(seen_row);
            end

            if (out_valid && out_ready)
            begin
                got.row = result_row;
                got.value = {value_7, value_6, value_5, value_4,
                             value_3, value_2, value_1, value_0};
                got.is_last = final_row;
                if (expected_products.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected product row %0d (expected none), final_row %0b",
                             $time, got.row, got.is_last);
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (got.row !== want.row)
                    begin
                        note_mismatch("result_row", longint'(want.row), longint'(got.row));
                    end
                    for (int j = 0; j < MAX_COLS; j++)
                    begin
                        if (got.value[j] !== want.value[j])
                        begin
                            note_mismatch($sformatf("value_%0d of row %0d", j, want.row),
                                          longint'($signed(want.value[j])),
                                          longint'($signed(got.value[j])));
                        end
                    end
                    if (got.is_last !== want.is_last)
                    begin
                        note_mismatch($sformatf("final_row of row %0d", want.row),
                                      longint'(want.is_last), longint'(got.is_last));
                    end
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("** weighted_gram_accumulator: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_row(input gram_row_t r);
        pending_rows.push_back(r);
        rows_pushed++;
    endtask

    function automatic gram_row_t uniform_row(input logic [ENTRY_W-1:0] v,
                                              input logic [WEIGHT_W-1:0] w,
                                              input logic is_last);
        gram_row_t r;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            r.entry[c] = v;
        end
        r.weight = w;
        r.is_last = is_last;
        return r;
    endfunction

    // Entries lean toward the extremes and small magnitudes, where rounding and
    // sign handling are most likely to go wrong; the rest are uniform.
    function automatic gram_row_t random_row(input logic is_last);
        gram_row_t r;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            case ($urandom_range(9))
                0: r.entry[c] = ENTRY_MIN;
                1: r.entry[c] = ENTRY_MAX;
                2: r.entry[c] = '0;
                3: r.entry[c] = ENTRY_W'($urandom_range(255)) ^ {ENTRY_W{$urandom_range(1) == 1}};
                default: r.entry[c] = ENTRY_W'($urandom);
            endcase
        end
        case ($urandom_range(7))
            0: r.weight = '0;
            1: r.weight = WEIGHT_MAX;
            2: r.weight = WEIGHT_UNIT;
            default: r.weight = WEIGHT_W'($urandom);
        endcase
        r.is_last = is_last;
        return r;
    endfunction

    task automatic push_set(input int len, input bit terminate);
        for (int k = 0; k < len; k++)
        begin
            push_row(random_row(terminate && (k == len - 1)));
        end
    endtask

    // Waits until every row has been taken and every predicted product row
    // has come out, then lets a row with no output finish inside the block.
    task automatic settle();
        do
        begin
            @(negedge clk);
        end
        while (rows_accepted != rows_pushed || expected_products.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DAT_W-1:0] cols, input logic [CFG_DAT_W-1:0] wt);
        settle();
        cfg_write(REG_COLS_IN_USE, cols);
        cfg_write(REG_WEIGHTING_ON, wt);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        gram_row_t r;
        int        send_rates[4];
        int        stall_rates[4];
        int        chunk_rows;
        int        len;

        send_rates  = '{0, 53, 0, 19};
        stall_rates = '{0, 0, 53, 19};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows under the reset settings: eight columns, weighted.
        push_row(uniform_row(ENTRY_MAX, WEIGHT_MAX, 1'b0));
        push_row(uniform_row(ENTRY_MIN, '0, 1'b0));
        r = uniform_row(ENTRY_MAX, WEIGHT_UNIT, 1'b1);
        for (int c = 0; c < MAX_COLS; c += 2)
        begin
            r.entry[c] = ENTRY_MIN;
        end
        push_row(r);
        // A set of one row with the largest possible terms.
        push_row(uniform_row(ENTRY_MIN, WEIGHT_MAX, 1'b1));
        // Rounding: with a weight of one LSB, +128*128 is exactly half an LSB and rounds
        // up, -128*128 rounds up to zero, and -128*129 falls to minus one.
        r = uniform_row('0, 16'd1, 1'b1);
        r.entry[0] = 16'sd128;
        r.entry[1] = 16'sd128;
        r.entry[2] = -16'sd128;
        r.entry[3] = -16'sd129;
        r.entry[4] = 16'sd1;
        r.entry[5] = -16'sd1;
        r.entry[7] = 16'sd2;
        push_row(r);
        push_row(uniform_row('0, WEIGHT_MAX, 1'b1));

        // Count above the maximum acts as eight; weighting data with bit 0
        // clear turns weighting off, so the row weight must be ignored.
        set_config(4'd15, 4'hE);
        r = random_row(1'b0);
        r.weight = 16'd12345;
        push_row(r);
        push_row(uniform_row(16'hFFFF, '0, 1'b1));

        // A count of zero acts as one column.
        set_config(4'd0, 4'd1);
        r = uniform_row(ENTRY_MAX, WEIGHT_MAX, 1'b1);
        r.entry[0] = ENTRY_MIN;
        push_row(r);
        set_config(4'd1, 4'd0);
        push_row(random_row(1'b1));

        // Count lowered in the middle of a set: the wider entries stay hidden
        // and must be gone once the set has been emitted.
        set_config(4'd8, 4'd1);
        push_row(random_row(1'b0));
        push_row(random_row(1'b0));
        set_config(4'd3, 4'd1);
        push_row(random_row(1'b1));
        push_row(random_row(1'b1));
        set_config(4'd8, 4'd1);
        push_row(random_row(1'b1));

        // A write to an unmapped index leaves both registers as they were.
        settle();
        cfg_write(REG_SPARE, 4'hF);
        push_row(random_row(1'b1));

        // Saturation: at two columns and the largest weight each row adds just
        // under 2^31 to every entry, so 258 rows drive the diagonals past the
        // top of the range and the cross term past the bottom; then a few rows
        // of the opposite sign pull the cross term back off the limit.
        set_config(4'd2, 4'd1);
        for (int k = 0; k < 258; k++)
        begin
            r = random_row(1'b0);
            r.entry[0] = ENTRY_MIN;
            r.entry[1] = ENTRY_MAX;
            r.weight = WEIGHT_MAX;
            push_row(r);
        end
        for (int k = 0; k < 6; k++)
        begin
            r = random_row(k == 5);
            r.entry[0] = ENTRY_MIN;
            r.entry[1] = ENTRY_MIN;
            r.weight = WEIGHT_MAX;
            push_row(r);
        end

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering full-width sets, so the block must stall its input.
        set_config(4'd8, 4'd1);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        for (int k = 0; k < 3; k++)
        begin
            push_set(3, 1'b1);
        end

        // Random part, one block per idling pattern. Each block changes the
        // settings twice; a set left open carries over into the next setting.
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int chunk = 0; chunk < 2; chunk++)
            begin
                set_config(CFG_DAT_W'($urandom_range(15)), CFG_DAT_W'($urandom_range(15)));
                send_idle_pct = send_rates[phase];
                stall_pct = stall_rates[phase];
                chunk_rows = 0;
                while (chunk_rows < 4)
                begin
                    len = $urandom_range(1, 6);
                    push_set(len, $urandom_range(9) != 0);
                    chunk_rows += len;
                end
            end
        end

        settle();
        if (expected_products.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d product rows never arrived", $time, expected_products.size());
        end
        if (mismatches == 0)
        begin
            $display("** weighted_gram_accumulator: PASSED **");
        end
        else
        begin
            $display("** weighted_gram_accumulator: FAILED **");
        end
        $finish;
    end

endmodule
